>>> hw/rtl/rcps_pkg.sv
package rcps_pkg;

  localparam int DEF_SCREEN_HEIGHT = 512;
  localparam int DEF_TEX_SIZE      = 64;

  localparam int CFG_INDEX_W = 8;
  localparam int COLOR_W     = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_CEILING = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FLOOR   = 8'd1;

  typedef enum logic [1:0] {
    KIND_CEILING = 2'd0,
    KIND_WALL    = 2'd1,
    KIND_FLOOR   = 2'd2
  } pixel_kind_t;

  // per-pixel fields that ride alongside the divider chains
  typedef struct packed {
    logic [11:0] col;
    logic [8:0]  row;
    pixel_kind_t kind;
    logic [1:0]  tex_idx;
    logic [5:0]  tex_col;
    logic        zero_row;
  } side_t;

  function automatic logic [1:0] pick_texture(input logic side, input logic xpos,
                                              input logic ypos);
    logic [1:0] idx;
    if (!side) begin
      idx = xpos ? 2'd2 : 2'd3;
    end else begin
      idx = ypos ? 2'd1 : 2'd0;
    end
    return idx;
  endfunction

endpackage

>>> hw/rtl/rcps_div_cell.sv
module rcps_div_cell #(
  parameter int QW = 8,
  parameter int DW = 8,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [QW-1:0] in_quo,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_div,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_rem,
  output logic [DW-1:0] out_div,
  output logic [PW-1:0] out_pay
);

  logic          vld;
  logic [QW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [PW-1:0] pay;

  logic [DW:0]   shifted;
  logic          ge;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_next;
  logic [QW-1:0] quo_next;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    shifted  = {in_rem, in_quo[QW-1]};
    ge       = shifted >= {1'b0, in_div};
    diff     = shifted - {1'b0, in_div};
    rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
    quo_next = {in_quo[QW-2:0], ge};
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      quo <= quo_next;
      rem <= rem_next;
      dvs <= in_div;
      pay <= in_pay;
    end
  end

  assign out_valid = vld;
  assign out_quo   = quo;
  assign out_rem   = rem;
  assign out_div   = dvs;
  assign out_pay   = pay;

endmodule

>>> hw/rtl/rcps_div_chain.sv
module rcps_div_chain #(
  parameter int QW = 8,
  parameter int DW = 8,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [QW-1:0] in_quo,
  input  logic [DW-1:0] in_div,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_rem,
  output logic [PW-1:0] out_pay
);

  // one cell per quotient bit, msb first
  logic          vld_w [QW+1];
  logic          rdy_w [QW+1];
  logic [QW-1:0] quo_w [QW+1];
  logic [DW-1:0] rem_w [QW+1];
  logic [DW-1:0] div_w [QW+1];
  logic [PW-1:0] pay_w [QW+1];

  assign vld_w[0] = in_valid;
  assign in_ready = rdy_w[0];
  assign quo_w[0] = in_quo;
  assign rem_w[0] = '0;
  assign div_w[0] = in_div;
  assign pay_w[0] = in_pay;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    rcps_div_cell #(
      .QW(QW),
      .DW(DW),
      .PW(PW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vld_w[i]),
      .in_ready (rdy_w[i]),
      .in_quo   (quo_w[i]),
      .in_rem   (rem_w[i]),
      .in_div   (div_w[i]),
      .in_pay   (pay_w[i]),
      .out_valid(vld_w[i+1]),
      .out_ready(rdy_w[i+1]),
      .out_quo  (quo_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_div  (div_w[i+1]),
      .out_pay  (pay_w[i+1])
    );
  end

  assign rdy_w[QW]  = out_ready;
  assign out_valid  = vld_w[QW];
  assign out_quo    = quo_w[QW];
  assign out_rem    = rem_w[QW];
  assign out_pay    = pay_w[QW];

endmodule

>>> hw/rtl/raycast_column_pixel_shader.sv
// Raycast column pixel shader.
// Pixels enter on the s_axis stream, one per request, and leave on m_axis in
// the same order, one result per pixel, with pixel_kind on m_axis_tuser.
// Ceiling and floor colors are written on the cfg channel (index 0 ceiling,
// index 1 floor, other indexes ignored); cfg_ready is always high.
// Pipeline: an input register, a chain of N1W divider cells for the line
// height (N1W = clog2(SCREEN_HEIGHT*256+1)), one register forming the scaled
// row offset, a chain of NW cells for the texture row (NW = N1W +
// clog2(TEX_SIZE+1)), a further NW cells for the modulo when TEX_SIZE is not
// a power of two, and the output register.
// Throughput is one pixel per cycle while m_axis_tready stays high.
// Each cell holds its item until the next one takes it, so a stall on
// m_axis fills bubbles first and only then pushes back to s_axis_tready.
// Reset empties the pipeline and clears both colors to zero.
module raycast_column_pixel_shader #(
  parameter int SCREEN_HEIGHT = rcps_pkg::DEF_SCREEN_HEIGHT,
  parameter int TEX_SIZE      = rcps_pkg::DEF_TEX_SIZE
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // col[11:0], row[20:12], hit_side[21], dir_x_positive[22], dir_y_positive[23],
  // perp_dist[39:24], tex_column[45:40], span_start[55:46], span_end[65:56]
  input  logic [71:0]                          s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_col[11:0], out_row[20:12], solid_color[44:21], texture_index[46:45],
  // texel_col[52:47], texel_row[58:53]
  output logic [63:0]                          m_axis_tdata,
  // pixel_kind[1:0]
  output logic [1:0]                           m_axis_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rcps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rcps_pkg::COLOR_W-1:0]         cfg_data
);

  import rcps_pkg::*;

  localparam int  N1       = SCREEN_HEIGHT * 256;
  localparam int  N1W      = $clog2(N1 + 1);
  localparam int  TXW      = $clog2(TEX_SIZE + 1);
  localparam int  NW       = N1W + TXW;
  localparam int  SW       = N1W + 1;
  localparam int  HALF     = SCREEN_HEIGHT / 2;
  localparam int  RW       = (TXW > 6) ? TXW : 6;
  localparam bit  TEX_POW2 = (TEX_SIZE & (TEX_SIZE - 1)) == 0;
  localparam int  PW       = $bits(side_t);

  // configuration
  logic [COLOR_W-1:0] ceiling_rgb;
  logic [COLOR_W-1:0] floor_rgb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_rgb <= '0;
      floor_rgb   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CEILING: ceiling_rgb <= cfg_data;
        REG_FLOOR:   floor_rgb   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: classify and pick the texture
  logic [11:0] in_col;
  logic [8:0]  in_row;
  logic [15:0] in_dist;
  logic [9:0]  in_start;
  logic [9:0]  in_end;
  side_t       side_next;

  logic        f_vld;
  logic        f_ready;
  side_t       f_side;
  logic [15:0] f_dist;
  logic        d1_in_ready;

  always_comb begin
    in_col   = s_axis_tdata[11:0];
    in_row   = s_axis_tdata[20:12];
    in_dist  = s_axis_tdata[39:24];
    in_start = s_axis_tdata[55:46];
    in_end   = s_axis_tdata[65:56];

    side_next.col     = in_col;
    side_next.row     = in_row;
    side_next.tex_idx = pick_texture(s_axis_tdata[21], s_axis_tdata[22], s_axis_tdata[23]);
    side_next.tex_col = s_axis_tdata[45:40];
    if ({1'b0, in_row} >= in_end) begin
      side_next.kind = KIND_FLOOR;
    end else if ({1'b0, in_row} < in_start) begin
      side_next.kind = KIND_CEILING;
    end else begin
      side_next.kind = KIND_WALL;
    end
    side_next.zero_row = side_next.kind != KIND_WALL;
  end

  assign f_ready       = !f_vld || d1_in_ready;
  assign s_axis_tready = f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (f_ready) begin
      f_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && s_axis_tvalid) begin
      f_side <= side_next;
      f_dist <= (in_dist == '0) ? 16'd1 : in_dist;
    end
  end

  // line height = SCREEN_HEIGHT*256 / dist
  logic           d1_vld;
  logic           mid_ready;
  logic [N1W-1:0] d1_quo;
  side_t          d1_side;

  rcps_div_chain #(
    .QW(N1W),
    .DW(16),
    .PW(PW)
  ) u_line_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_vld),
    .in_ready (d1_in_ready),
    .in_quo   (N1W'(N1)),
    .in_div   (f_dist),
    .in_pay   (f_side),
    .out_valid(d1_vld),
    .out_ready(mid_ready),
    .out_quo  (d1_quo),
    .out_rem  (),
    .out_pay  (d1_side)
  );

  // offset from the line top, scaled by the texture size
  logic signed [SW-1:0] diff;
  logic [NW-1:0]        num_next;
  side_t                mid_side_next;

  logic           mid_vld;
  side_t          mid_side;
  logic [NW-1:0]  mid_num;
  logic [N1W-1:0] mid_line;
  logic           d2_in_ready;

  always_comb begin
    diff = $signed({{(SW-9){1'b0}}, d1_side.row}) + $signed({2'b00, d1_quo[N1W-1:1]})
         - $signed(SW'(HALF));
    num_next = NW'(diff[N1W-1:0]) * NW'(TEX_SIZE);
    mid_side_next          = d1_side;
    mid_side_next.zero_row = d1_side.zero_row || diff[SW-1] || (d1_quo == '0);
  end

  assign mid_ready = !mid_vld || d2_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
    end else if (mid_ready) begin
      mid_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && d1_vld) begin
      mid_side <= mid_side_next;
      mid_num  <= num_next;
      mid_line <= d1_quo;
    end
  end

  // texture row before wrapping
  logic          d2_vld;
  logic          d2_ready;
  logic [NW-1:0] d2_quo;
  side_t         d2_side;

  rcps_div_chain #(
    .QW(NW),
    .DW(N1W),
    .PW(PW)
  ) u_row_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mid_vld),
    .in_ready (d2_in_ready),
    .in_quo   (mid_num),
    .in_div   (mid_line),
    .in_pay   (mid_side),
    .out_valid(d2_vld),
    .out_ready(d2_ready),
    .out_quo  (d2_quo),
    .out_rem  (),
    .out_pay  (d2_side)
  );

  // wrap into the texture
  logic           t_vld;
  logic           t_ready;
  logic [TXW-1:0] t_rem;
  side_t          t_side;

  if (TEX_POW2) begin : g_mask
    assign t_vld    = d2_vld;
    assign d2_ready = t_ready;
    assign t_rem    = TXW'(d2_quo & NW'(TEX_SIZE - 1));
    assign t_side   = d2_side;
  end else begin : g_mod
    rcps_div_chain #(
      .QW(NW),
      .DW(TXW),
      .PW(PW)
    ) u_wrap (
      .clk      (clk),
      .rst      (rst),
      .in_valid (d2_vld),
      .in_ready (d2_ready),
      .in_quo   (d2_quo),
      .in_div   (TXW'(TEX_SIZE)),
      .in_pay   (d2_side),
      .out_valid(t_vld),
      .out_ready(t_ready),
      .out_quo  (),
      .out_rem  (t_rem),
      .out_pay  (t_side)
    );
  end

  // output register
  logic [RW-1:0]      rem_ext;
  logic [COLOR_W-1:0] color_next;
  logic [5:0]         trow_next;

  logic               out_vld;
  side_t              out_side;
  logic [COLOR_W-1:0] out_color;
  logic [5:0]         out_trow;

  always_comb begin
    rem_ext = RW'(t_rem);
    unique case (t_side.kind)
      KIND_CEILING: color_next = ceiling_rgb;
      KIND_FLOOR:   color_next = floor_rgb;
      default:      color_next = '0;
    endcase
    trow_next = t_side.zero_row ? 6'd0 : rem_ext[5:0];
  end

  assign t_ready = !out_vld || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (t_ready) begin
      out_vld <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (t_ready && t_vld) begin
      out_side  <= t_side;
      out_color <= color_next;
      out_trow  <= trow_next;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = out_side.kind;
  assign m_axis_tdata  = {5'd0, out_trow, out_side.tex_col, out_side.tex_idx, out_color,
                          out_side.row, out_side.col};

endmodule

>>> test/raycast_column_pixel_shader_checker.sv
`timescale 1ns / 1ps

module raycast_column_pixel_shader_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [71:0]                      s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [63:0]                      m_axis_tdata,
  input  logic [1:0]                       m_axis_tuser,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [rcps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rcps_pkg::COLOR_W-1:0]     cfg_data,
  output int                               mismatch_count,
  output int                               pixels_in_flight
);

  import rcps_pkg::*;

  localparam longint SCREEN_H = DEF_SCREEN_HEIGHT;
  localparam longint TEX_N    = DEF_TEX_SIZE;

  typedef struct packed {
    logic [11:0]  col;
    logic [8:0]   row;
    pixel_kind_t  kind;
    logic [23:0]  color;
    logic [1:0]   tex_idx;
    logic [5:0]   tex_col;
    logic [5:0]   tex_row;
  } shaded_pixel_t;

  logic [COLOR_W-1:0] ceiling_rgb;
  logic [COLOR_W-1:0] floor_rgb;
  shaded_pixel_t      shaded_q[$];
  int                 pixel_count;

  initial begin
    mismatch_count   = 0;
    pixels_in_flight = 0;
    pixel_count      = 0;
    ceiling_rgb      = '0;
    floor_rgb        = '0;
  end

  // exact integer texture row of a wall pixel
  function automatic logic [5:0] wall_texel_row(input logic [8:0] y, input logic [15:0] perp);
    longint d;
    longint line_h;
    longint top;
    longint num;
    d = (perp == 16'd0) ? 64'sd1 : longint'(perp);
    line_h = (SCREEN_H * 256) / d;
    if (line_h == 0) begin
      return 6'd0;
    end
    top = SCREEN_H / 2 - line_h / 2;
    num = (longint'(y) - top) * TEX_N;
    if (num < 0) begin
      return 6'd0;
    end
    return 6'((num / line_h) % TEX_N);
  endfunction

  function automatic shaded_pixel_t shade_pixel(input logic [71:0] req);
    shaded_pixel_t px;
    logic [8:0]    y;
    logic [9:0]    span_start;
    logic [9:0]    span_end;
    y          = req[20:12];
    span_start = req[55:46];
    span_end   = req[65:56];
    px.col     = req[11:0];
    px.row     = y;
    px.tex_col = req[45:40];
    px.color   = '0;
    px.tex_row = '0;
    if (!req[21]) begin
      px.tex_idx = req[22] ? 2'd2 : 2'd3;
    end else begin
      px.tex_idx = req[23] ? 2'd1 : 2'd0;
    end
    // floor takes priority when the span is inverted
    if ({1'b0, y} >= span_end) begin
      px.kind  = KIND_FLOOR;
      px.color = floor_rgb;
    end else if ({1'b0, y} < span_start) begin
      px.kind  = KIND_CEILING;
      px.color = ceiling_rgb;
    end else begin
      px.kind    = KIND_WALL;
      px.tex_row = wall_texel_row(y, req[39:24]);
    end
    return px;
  endfunction

  task automatic compare_field(input string field, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("pixel %0d: %s expected %0h, got %0h", pixel_count, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    shaded_pixel_t want;
    if (rst) begin
      shaded_q.delete();
      ceiling_rgb = '0;
      floor_rgb   = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CEILING) begin
          ceiling_rgb = cfg_data;
        end else if (cfg_index == REG_FLOOR) begin
          floor_rgb = cfg_data;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        shaded_q.push_back(shade_pixel(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (shaded_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("pixel %0d: result with no pixel pending, data %0h", pixel_count,
                     m_axis_tdata);
          end
        end else begin
          want = shaded_q.pop_front();
          compare_field("out_col", 24'(want.col), 24'(m_axis_tdata[11:0]));
          compare_field("out_row", 24'(want.row), 24'(m_axis_tdata[20:12]));
          compare_field("pixel_kind", 24'(want.kind), 24'(m_axis_tuser));
          compare_field("solid_color", want.color, m_axis_tdata[44:21]);
          compare_field("texture_index", 24'(want.tex_idx), 24'(m_axis_tdata[46:45]));
          compare_field("texel_col", 24'(want.tex_col), 24'(m_axis_tdata[52:47]));
          compare_field("texel_row", 24'(want.tex_row), 24'(m_axis_tdata[58:53]));
        end
        pixel_count++;
      end
    end
    pixels_in_flight <= shaded_q.size();
  end

endmodule

>>> test/raycast_column_pixel_shader_tb.sv
`timescale 1ns / 1ps

module raycast_column_pixel_shader_tb;
  import rcps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int SCREEN_H = DEF_SCREEN_HEIGHT;
  // indexes outside the register map, writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX = 8'hFF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [71:0]            s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [63:0]            m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int pixels_in_flight;
  int gap_pct;
  int stall_pct = 0;
  int stall_left = 0;
  int cycle_count = 0;

  raycast_column_pixel_shader uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  raycast_column_pixel_shader_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .pixels_in_flight (pixels_in_flight)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // output back-pressure in bursts
  always @(posedge clk) begin
    if (rst || stall_pct == 0) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= (stall_left == 1);
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(1, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [71:0] make_pixel(input logic [11:0] col, input logic [8:0] row,
                                             input logic side, input logic xpos,
                                             input logic ypos, input logic [15:0] perp,
                                             input logic [5:0] tcol,
                                             input logic [9:0] span_start,
                                             input logic [9:0] span_end);
    return {6'd0, span_end, span_start, tcol, perp, ypos, xpos, side, row, col};
  endfunction

  function automatic logic [71:0] random_pixel();
    logic [15:0] perp;
    logic [8:0]  row;
    logic [9:0]  span_start;
    logic [9:0]  span_end;
    int          line_h;
    int          top;
    int          bot;
    case ($urandom_range(0, 3))
      0: perp = 16'($urandom_range(0, 255));
      1: perp = 16'($urandom_range(256, 2047));
      2: perp = 16'($urandom_range(2048, 65535));
      default: perp = 16'($urandom);
    endcase
    row = 9'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      // span as the column renderer would produce it for this distance
      line_h = (SCREEN_H * 256) / ((perp == 16'd0) ? 1 : int'(perp));
      top = SCREEN_H / 2 - line_h / 2;
      bot = top + line_h;
      if (top < 0) top = 0;
      if (top > SCREEN_H) top = SCREEN_H;
      if (bot < 0) bot = 0;
      if (bot > SCREEN_H) bot = SCREEN_H;
      span_start = 10'(top);
      span_end   = 10'(bot);
      if ($urandom_range(0, 2) == 0) begin
        row = 9'(top + $urandom_range(0, 6) - 3);
      end else if ($urandom_range(0, 2) == 0) begin
        row = 9'(bot + $urandom_range(0, 6) - 3);
      end
    end else begin
      span_start = 10'($urandom);
      span_end   = 10'($urandom);
    end
    return make_pixel(12'($urandom), row, 1'($urandom), 1'($urandom), 1'($urandom), perp,
                      6'($urandom), span_start, span_end);
  endfunction

  task automatic send_pixel(input logic [71:0] req);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tdata  <= req;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_colors(input logic [COLOR_W-1:0] ceiling, input logic [COLOR_W-1:0] flr);
    write_reg(REG_CEILING, ceiling);
    write_reg(REG_UNMAPPED, 24'($urandom));
    write_reg(REG_FLOOR, flr);
    write_reg(REG_LAST_INDEX, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pixels_in_flight != 0);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(random_pixel());
    end
    wait_drained();
  endtask

  initial begin
    gap_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_colors(24'h000000, 24'hFFFFFF);
    gap_pct = 10;
    stall_pct <= 10;
    // floor, ceiling and inverted spans, then a wall pixel on the last row
    send_pixel(make_pixel(12'h000, 9'd0, 1'b0, 1'b0, 1'b0, 16'd256, 6'd0, 10'd0, 10'd0));
    send_pixel(make_pixel(12'hFFF, 9'd511, 1'b1, 1'b1, 1'b1, 16'hFFFF, 6'd63,
                          10'd1023, 10'd1023));
    send_pixel(make_pixel(12'h5A5, 9'd100, 1'b0, 1'b1, 1'b0, 16'd256, 6'd21, 10'd200,
                          10'd50));
    send_pixel(make_pixel(12'hA5A, 9'd10, 1'b1, 1'b0, 1'b1, 16'd256, 6'd42, 10'd200, 10'd50));
    send_pixel(make_pixel(12'd7, 9'd511, 1'b0, 1'b0, 1'b1, 16'd256, 6'd5, 10'd0, 10'd512));
    // zero distance and the nearest distances
    send_pixel(make_pixel(12'd1, 9'd300, 1'b0, 1'b1, 1'b1, 16'd0, 6'd9, 10'd0, 10'd512));
    send_pixel(make_pixel(12'd2, 9'd0, 1'b1, 1'b1, 1'b0, 16'd0, 6'd9, 10'd0, 10'd512));
    send_pixel(make_pixel(12'd3, 9'd511, 1'b0, 1'b0, 1'b0, 16'd1, 6'd9, 10'd0, 10'd512));
    // farthest wall: rows above, at and below the line top
    send_pixel(make_pixel(12'd4, 9'd254, 1'b1, 1'b0, 1'b0, 16'hFFFF, 6'd1, 10'd0, 10'd512));
    send_pixel(make_pixel(12'd4, 9'd255, 1'b1, 1'b0, 1'b0, 16'hFFFF, 6'd1, 10'd0, 10'd512));
    send_pixel(make_pixel(12'd4, 9'd256, 1'b1, 1'b0, 1'b0, 16'hFFFF, 6'd1, 10'd0, 10'd512));
    // line top at row 128, pixel above it still inside the span
    send_pixel(make_pixel(12'd8, 9'd127, 1'b0, 1'b1, 1'b0, 16'd512, 6'd33, 10'd100,
                          10'd400));
    send_pixel(make_pixel(12'd8, 9'd383, 1'b0, 1'b1, 1'b0, 16'd512, 6'd33, 10'd100,
                          10'd400));
    send_pixel(make_pixel(12'h555, 9'h155, 1'b1, 1'b1, 1'b0, 16'hAAAA, 6'h15, 10'h000,
                          10'h3FF));
    send_pixel(make_pixel(12'hAAA, 9'h0AA, 1'b0, 1'b0, 1'b1, 16'h5555, 6'h2A, 10'h000,
                          10'h2AA));
    // every side and direction combination on a wall pixel
    for (int c = 0; c < 8; c++) begin
      send_pixel(make_pixel(12'(c), 9'(60 * c + 3), c[0], c[1], c[2], 16'd256, 6'(c * 8),
                            10'd0, 10'd512));
    end
    wait_drained();

    set_colors(24'($urandom), 24'($urandom));
    gap_pct = 25;
    stall_pct <= 20;
    run_random(600);

    set_colors(24'hFFFFFF, 24'h000000);
    gap_pct = 40;
    stall_pct <= 45;
    run_random(600);

    // closing stretch with both sides running flat out
    set_colors(24'($urandom), 24'($urandom));
    gap_pct = 0;
    stall_pct <= 0;
    run_random(630);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pixels_in_flight == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
